>>> sv/slhw_pkg.sv
package slhw_pkg;

    typedef enum logic [1:0] {
        REQ_START = 2'd0,
        REQ_STOP  = 2'd1,
        REQ_CHUNK = 2'd2,
        REQ_TICK  = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_STARTING  = 3'd1,
        PH_STREAMING = 3'd2,
        PH_DEGRADED  = 3'd3,
        PH_STALLED   = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        ST_NONE    = 2'd0,
        ST_SILENT  = 2'd1,
        ST_GARBAGE = 2'd2
    } t_stall;

    typedef enum logic [1:0] {
        ER_OK     = 2'd0,
        ER_CRC    = 2'd1,
        ER_NORESP = 2'd2,
        ER_PROTO  = 2'd3
    } t_err;

    typedef enum logic [2:0] {
        CFG_STARTUP_GRACE   = 3'd0,
        CFG_SILENT_TIMEOUT  = 3'd1,
        CFG_GARBAGE_TIMEOUT = 3'd2,
        CFG_MIN_PACKETS     = 3'd3,
        CFG_MIN_PASS_RATE   = 3'd4
    } t_cfg_idx;

    localparam int unsigned TIME_W  = 63;
    localparam int unsigned TMO_W   = 40;
    localparam int unsigned CNT_W   = 32;
    localparam int unsigned RATE_W  = 17;
    localparam int unsigned CFG_W   = 40;
    localparam int unsigned CFG_A_W = 3;

    localparam logic [TMO_W-1:0]  RST_STARTUP_GRACE   = 40'd2000000000;
    localparam logic [TMO_W-1:0]  RST_SILENT_TIMEOUT  = 40'd500000000;
    localparam logic [TMO_W-1:0]  RST_GARBAGE_TIMEOUT = 40'd500000000;
    localparam logic [CNT_W-1:0]  RST_MIN_PACKETS     = 32'd100;
    localparam logic [RATE_W-1:0] RST_MIN_PASS_RATE   = 17'd58982;

endpackage

>>> sv/stream_link_health_watchdog.sv
// channel   direction  handshake                  payload
// event     in         i_in_valid / o_in_ready    req_type, time_ns, good/bad_packet_total
// status    out        o_out_valid / i_out_ready  link_phase, stall_kind, error_code, flags
// config    in         i_cfg_we (no wait)         i_cfg_index, i_cfg_data
//
// one event per cycle sustained while status words are taken; a status word is valid
// once the event has passed the input register and then the result register. the
// pass-rate multiply and the elapsed-time compares sit between those two registers.
// reset is synchronous, active low; config, state and valid registers return to defaults.
// a stalled status word holds the result register; the input register still
// takes one more event, then o_in_ready drops until the status word leaves.
module stream_link_health_watchdog (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [1:0]                      i_req_type,
    input  logic [slhw_pkg::TIME_W-1:0]     i_time_ns,
    input  logic [slhw_pkg::CNT_W-1:0]      i_good_packet_total,
    input  logic [slhw_pkg::CNT_W-1:0]      i_bad_packet_total,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [2:0]                      o_link_phase,
    output logic [1:0]                      o_stall_kind,
    output logic [1:0]                      o_error_code,
    output logic                            o_phase_changed,
    output logic                            o_stall_raised,
    input  logic                            i_cfg_we,
    input  logic [slhw_pkg::CFG_A_W-1:0]    i_cfg_index,
    input  logic [slhw_pkg::CFG_W-1:0]      i_cfg_data
);

    localparam int unsigned TOT_W  = slhw_pkg::CNT_W + 1;
    localparam int unsigned PROD_W = slhw_pkg::RATE_W + TOT_W;

    // configuration
    logic [slhw_pkg::TMO_W-1:0]  r_startup_grace;
    logic [slhw_pkg::TMO_W-1:0]  r_silent_timeout;
    logic [slhw_pkg::TMO_W-1:0]  r_garbage_timeout;
    logic [slhw_pkg::CNT_W-1:0]  r_min_packets;
    logic [slhw_pkg::RATE_W-1:0] r_min_pass_rate;

    // input register
    logic                        r_in_valid;
    slhw_pkg::t_req              r_req;
    logic [slhw_pkg::TIME_W-1:0] r_now;
    logic [slhw_pkg::CNT_W-1:0]  r_good;
    logic [slhw_pkg::CNT_W-1:0]  r_bad;

    // link state
    slhw_pkg::t_phase            r_phase, n_phase;
    slhw_pkg::t_stall            r_stall, n_stall;
    slhw_pkg::t_err              r_err, n_err;
    logic [slhw_pkg::TIME_W-1:0] r_start_time, n_start_time;
    logic [slhw_pkg::TIME_W-1:0] r_last_bytes, n_last_bytes;
    logic [slhw_pkg::TIME_W-1:0] r_last_valid, n_last_valid;
    logic [slhw_pkg::CNT_W-1:0]  r_good_seen, n_good_seen;

    // result register
    logic                        r_out_valid;
    slhw_pkg::t_phase            r_out_phase;
    slhw_pkg::t_stall            r_out_stall;
    slhw_pkg::t_err              r_out_err;
    logic                        r_out_changed;
    logic                        r_out_raised;

    logic                        advance;
    logic                        take_in;
    logic                        n_changed;
    logic                        n_raised;
    logic [TOT_W-1:0]            total;
    logic [PROD_W-1:0]           rate_prod;
    logic [PROD_W-1:0]           good_scaled;
    logic                        below;
    logic                        progressed;

    // signed difference of two 63-bit times against a non-negative threshold
    function automatic logic f_elapsed_ge(
        input logic [slhw_pkg::TIME_W-1:0] now,
        input logic [slhw_pkg::TIME_W-1:0] then_t,
        input logic [slhw_pkg::TMO_W-1:0]  thr
    );
        logic signed [slhw_pkg::TIME_W:0] d;
        logic signed [slhw_pkg::TIME_W:0] t;
        d = $signed({1'b0, now}) - $signed({1'b0, then_t});
        t = $signed({{(slhw_pkg::TIME_W + 1 - slhw_pkg::TMO_W){1'b0}}, thr});
        return d >= t;
    endfunction

    assign advance  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign take_in  = i_in_valid && o_in_ready;

    assign total       = {1'b0, r_good} + {1'b0, r_bad};
    assign rate_prod   = PROD_W'(r_min_pass_rate) * PROD_W'(total);
    assign good_scaled = {{(PROD_W - slhw_pkg::CNT_W - 16){1'b0}}, r_good, 16'd0};
    assign below       = good_scaled < rate_prod;
    assign progressed  = r_good > r_good_seen;

    always_comb begin
        logic wd_run;
        logic silent;
        logic garbage;
        n_phase      = r_phase;
        n_stall      = r_stall;
        n_err        = r_err;
        n_start_time = r_start_time;
        n_last_bytes = r_last_bytes;
        n_last_valid = r_last_valid;
        n_good_seen  = r_good_seen;
        n_changed    = 1'b0;
        n_raised     = 1'b0;
        wd_run       = 1'b0;
        silent       = 1'b0;
        garbage      = 1'b0;

        case (r_req)
            slhw_pkg::REQ_START: begin
                if (r_phase == slhw_pkg::PH_IDLE) begin
                    n_start_time = r_now;
                    n_last_bytes = r_now;
                    n_last_valid = r_now;
                    n_good_seen  = r_good;
                    n_stall      = slhw_pkg::ST_NONE;
                    if (n_phase != slhw_pkg::PH_STARTING || n_err != slhw_pkg::ER_OK) begin
                        n_changed = 1'b1;
                    end
                    n_phase = slhw_pkg::PH_STARTING;
                    n_err   = slhw_pkg::ER_OK;
                end
            end
            slhw_pkg::REQ_STOP: begin
                // stopping notice folded into the final idle result
                if (r_phase != slhw_pkg::PH_IDLE) begin
                    n_stall   = slhw_pkg::ST_NONE;
                    n_phase   = slhw_pkg::PH_IDLE;
                    n_err     = slhw_pkg::ER_OK;
                    n_changed = 1'b1;
                end
            end
            slhw_pkg::REQ_CHUNK: begin
                n_last_bytes = r_now;
                n_good_seen  = r_good;
                if (progressed) begin
                    n_last_valid = r_now;
                end
                if (progressed && (n_phase == slhw_pkg::PH_STARTING ||
                                   n_phase == slhw_pkg::PH_IDLE ||
                                   n_phase == slhw_pkg::PH_STALLED)) begin
                    n_stall = slhw_pkg::ST_NONE;
                    if (n_phase != slhw_pkg::PH_STREAMING || n_err != slhw_pkg::ER_OK) begin
                        n_changed = 1'b1;
                    end
                    n_phase = slhw_pkg::PH_STREAMING;
                    n_err   = slhw_pkg::ER_OK;
                end
                if (n_phase == slhw_pkg::PH_STREAMING &&
                    total >= TOT_W'(r_min_packets) && below) begin
                    if (n_err != slhw_pkg::ER_CRC) begin
                        n_changed = 1'b1;
                    end
                    n_phase   = slhw_pkg::PH_DEGRADED;
                    n_err     = slhw_pkg::ER_CRC;
                    n_changed = 1'b1;
                end else if (n_phase == slhw_pkg::PH_DEGRADED && !below) begin
                    if (n_err != slhw_pkg::ER_OK) begin
                        n_changed = 1'b1;
                    end
                    n_phase   = slhw_pkg::PH_STREAMING;
                    n_err     = slhw_pkg::ER_OK;
                    n_changed = 1'b1;
                end
                wd_run = 1'b1;
            end
            slhw_pkg::REQ_TICK: begin
                wd_run = 1'b1;
            end
            default: begin
                wd_run = 1'b0;
            end
        endcase

        // stall watchdog, only once past the startup grace window
        if (wd_run && n_phase != slhw_pkg::PH_IDLE &&
            f_elapsed_ge(r_now, n_start_time, r_startup_grace)) begin
            silent  = f_elapsed_ge(r_now, n_last_bytes, r_silent_timeout);
            garbage = !silent && f_elapsed_ge(r_now, n_last_valid, r_garbage_timeout);
            if (silent || garbage) begin
                n_stall = silent ? slhw_pkg::ST_SILENT : slhw_pkg::ST_GARBAGE;
                if (n_phase != slhw_pkg::PH_STALLED) begin
                    n_phase   = slhw_pkg::PH_STALLED;
                    n_err     = silent ? slhw_pkg::ER_NORESP : slhw_pkg::ER_PROTO;
                    n_changed = 1'b1;
                    n_raised  = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_startup_grace   <= slhw_pkg::RST_STARTUP_GRACE;
            r_silent_timeout  <= slhw_pkg::RST_SILENT_TIMEOUT;
            r_garbage_timeout <= slhw_pkg::RST_GARBAGE_TIMEOUT;
            r_min_packets     <= slhw_pkg::RST_MIN_PACKETS;
            r_min_pass_rate   <= slhw_pkg::RST_MIN_PASS_RATE;
        end else if (i_cfg_we) begin
            case (slhw_pkg::t_cfg_idx'(i_cfg_index))
                slhw_pkg::CFG_STARTUP_GRACE: begin
                    r_startup_grace <= i_cfg_data[slhw_pkg::TMO_W-1:0];
                end
                slhw_pkg::CFG_SILENT_TIMEOUT: begin
                    r_silent_timeout <= i_cfg_data[slhw_pkg::TMO_W-1:0];
                end
                slhw_pkg::CFG_GARBAGE_TIMEOUT: begin
                    r_garbage_timeout <= i_cfg_data[slhw_pkg::TMO_W-1:0];
                end
                slhw_pkg::CFG_MIN_PACKETS: begin
                    r_min_packets <= i_cfg_data[slhw_pkg::CNT_W-1:0];
                end
                slhw_pkg::CFG_MIN_PASS_RATE: begin
                    r_min_pass_rate <= i_cfg_data[slhw_pkg::RATE_W-1:0];
                end
                default: begin
                    r_min_pass_rate <= r_min_pass_rate;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (take_in) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_req  <= slhw_pkg::t_req'(i_req_type);
            r_now  <= i_time_ns;
            r_good <= i_good_packet_total;
            r_bad  <= i_bad_packet_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= slhw_pkg::PH_IDLE;
            r_stall      <= slhw_pkg::ST_NONE;
            r_err        <= slhw_pkg::ER_OK;
            r_start_time <= '0;
            r_last_bytes <= '0;
            r_last_valid <= '0;
            r_good_seen  <= '0;
        end else if (advance) begin
            r_phase      <= n_phase;
            r_stall      <= n_stall;
            r_err        <= n_err;
            r_start_time <= n_start_time;
            r_last_bytes <= n_last_bytes;
            r_last_valid <= n_last_valid;
            r_good_seen  <= n_good_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_phase   <= n_phase;
            r_out_stall   <= n_stall;
            r_out_err     <= n_err;
            r_out_changed <= n_changed;
            r_out_raised  <= n_raised;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_link_phase    = r_out_phase;
    assign o_stall_kind    = r_out_stall;
    assign o_error_code    = r_out_err;
    assign o_phase_changed = r_out_changed;
    assign o_stall_raised  = r_out_raised;

    a_raise_is_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_stall_raised |->
            o_link_phase == slhw_pkg::PH_STALLED && o_phase_changed &&
            (o_error_code == slhw_pkg::ER_NORESP || o_error_code == slhw_pkg::ER_PROTO))
        else $error("stall raised without entering stalled phase");

    a_stall_kind_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            (o_link_phase == slhw_pkg::PH_STALLED) == (o_stall_kind != slhw_pkg::ST_NONE))
        else $error("stall kind disagrees with phase");

    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_link_phase == slhw_pkg::PH_IDLE |->
            o_error_code == slhw_pkg::ER_OK && !o_stall_raised)
        else $error("idle phase carries an error");

    a_state_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_phase) && $stable(r_err) && $stable(r_good_seen))
        else $error("link state moved without an event");

endmodule
